>>> sv/lsrc_pkg.sv
// Package for the line segment rectangle clipper.
// Holds region code constants, front-to-back queue entry type and helpers.
package lsrc_pkg;

  localparam int CoordW = 16;
  localparam int WideW  = 34;
  localparam int MaxPasses = 8;
  localparam int PassW = 4;
  localparam int QDepth = 2;
  localparam int QPtrW = 1;

  localparam logic [3:0] CODE_LEFT   = 4'd1;
  localparam logic [3:0] CODE_RIGHT  = 4'd2;
  localparam logic [3:0] CODE_BOTTOM = 4'd4;
  localparam logic [3:0] CODE_TOP    = 4'd8;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_BOTTOM = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] bottom;
    logic signed [CoordW-1:0] right;
    logic signed [CoordW-1:0] top;
  } window_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] y0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic [3:0] c0;
    logic [3:0] c1;
  } seg_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_MUL, ST_DIV, ST_APPLY, ST_DONE
  } back_state_t;

  function automatic logic [3:0] region(input logic signed [CoordW-1:0] x,
                                        input logic signed [CoordW-1:0] y,
                                        input window_t w);
    logic [3:0] c;
    c = '0;
    if (x < w.left) c |= CODE_LEFT;
    else if (x > w.right) c |= CODE_RIGHT;
    if (y < w.bottom) c |= CODE_BOTTOM;
    else if (y > w.top) c |= CODE_TOP;
    return c;
  endfunction

endpackage

>>> sv/lsrc_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on lsrc_pkg.
module lsrc_div
  import lsrc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [WideW-1:0] dividend,
  input  logic signed [WideW-1:0] divisor,
  output logic                    done,
  output logic signed [WideW-1:0] quotient
);

  localparam int CntW = $clog2(WideW + 1);

  logic [WideW-1:0] num;
  logic [WideW-1:0] den;
  logic [WideW:0]   rem;
  logic             neg;
  logic             busy;
  logic [CntW-1:0]  cnt;
  logic [WideW:0]   trial;

  assign trial = {rem[WideW-1:0], num[WideW-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(WideW);
        num  <= dividend[WideW-1] ? -dividend : dividend;
        den  <= divisor[WideW-1] ? -divisor : divisor;
        neg  <= dividend[WideW-1] ^ divisor[WideW-1];
        rem  <= '0;
      end else if (busy) begin
        if (!trial[WideW]) rem <= trial;
        else rem <= {rem[WideW-1:0], num[WideW-1]};
        num <= {num[WideW-2:0], ~trial[WideW]};
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -num : num;

endmodule

>>> sv/lsrc_front.sv
// Front part: takes segments, computes region codes, fills a two-entry queue.
// Depends on lsrc_pkg.
module lsrc_front
  import lsrc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CoordW-1:0] sx,
  input  logic signed [CoordW-1:0] sy,
  input  logic signed [CoordW-1:0] ex,
  input  logic signed [CoordW-1:0] ey,
  input  window_t                  win,
  output logic                     q_valid,
  input  logic                     q_ready,
  output seg_t                     q_data
);

  seg_t             mem [QDepth];
  logic [QPtrW-1:0] wp, rp;
  logic [QPtrW:0]   cnt;
  logic             push, pop;

  assign in_ready = cnt != (QPtrW+1)'(QDepth);
  assign q_valid  = cnt != '0;
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_data   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        mem[wp] <= '{x0: sx, y0: sy, x1: ex, y1: ey,
                     c0: region(sx, sy, win), c1: region(ex, ey, win)};
        wp <= wp + 1'b1;
      end
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (QPtrW+1)'(QDepth)) else $error("queue overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cnt == (QPtrW+1)'(QDepth) |-> !push) else $error("push into full queue");
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> cnt == $past(cnt) + 1'b1) else $error("count mismatch");

endmodule

>>> sv/lsrc_back.sv
// Back part: iterative clip passes with shared multiplier and serial divider.
// Depends on lsrc_pkg and lsrc_div.
module lsrc_back
  import lsrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  seg_t        q_data,
  input  window_t     win,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_data,
  output logic        out_acc
);

  back_state_t state, state_next;
  seg_t        seg;
  logic [PassW-1:0] pass;
  logic        mv0, vert;
  logic signed [CoordW:0]   nd, eo, dn;
  logic signed [WideW-1:0]  prod;
  logic signed [CoordW-1:0] base, edge_v;
  logic        div_start, div_done;
  logic signed [WideW-1:0]  quo;
  logic signed [CoordW-1:0] nv;
  logic [3:0]  cout;
  logic        acc_now, rej_now;

  // product goes straight into the divider at the launch edge
  assign prod = WideW'(nd) * WideW'(eo);

  lsrc_div u_div (.clk, .rst, .start(div_start), .dividend(prod),
                  .divisor({{(WideW-CoordW-1){dn[CoordW]}}, dn}),
                  .done(div_done), .quotient(quo));

  assign cout    = (seg.c0 != '0) ? seg.c0 : seg.c1;
  assign acc_now = (seg.c0 | seg.c1) == '0;
  assign rej_now = ((seg.c0 & seg.c1) != '0) || pass == PassW'(MaxPasses);
  assign q_ready = state == ST_IDLE;
  assign out_valid = state == ST_DONE;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (q_valid) state_next = ST_CHECK;
      ST_CHECK: if (acc_now || rej_now) state_next = ST_DONE;
                else state_next = ST_MUL;
      ST_MUL:   state_next = (dn == '0) ? ST_APPLY : ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_APPLY;
      ST_APPLY: state_next = ST_CHECK;
      ST_DONE:  if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign div_start = state == ST_MUL && dn != '0;
  assign nv = (dn == '0) ? base : CoordW'(WideW'(base) + quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        seg  <= q_data;
        pass <= '0;
      end
      ST_CHECK: begin
        out_acc <= acc_now;
        if (acc_now) out_data <= {seg.y1, seg.x1, seg.y0, seg.x0};
        else out_data <= '0;
        mv0  <= seg.c0 != '0;
        vert <= (cout & (CODE_TOP | CODE_BOTTOM)) != '0;
        if ((cout & (CODE_TOP | CODE_BOTTOM)) != '0) begin
          edge_v <= ((cout & CODE_TOP) != '0) ? win.top : win.bottom;
          base <= seg.x0;
          nd <= (CoordW+1)'(seg.x1) - (CoordW+1)'(seg.x0);
          eo <= (((cout & CODE_TOP) != '0) ? (CoordW+1)'(win.top) :
                 (CoordW+1)'(win.bottom)) - (CoordW+1)'(seg.y0);
          dn <= (CoordW+1)'(seg.y1) - (CoordW+1)'(seg.y0);
        end else begin
          edge_v <= ((cout & CODE_RIGHT) != '0) ? win.right : win.left;
          base <= seg.y0;
          nd <= (CoordW+1)'(seg.y1) - (CoordW+1)'(seg.y0);
          eo <= (((cout & CODE_RIGHT) != '0) ? (CoordW+1)'(win.right) :
                 (CoordW+1)'(win.left)) - (CoordW+1)'(seg.x0);
          dn <= (CoordW+1)'(seg.x1) - (CoordW+1)'(seg.x0);
        end
      end
      ST_APPLY: begin
        pass <= pass + 1'b1;
        if (mv0) begin
          seg.x0 <= vert ? nv : edge_v;
          seg.y0 <= vert ? edge_v : nv;
          seg.c0 <= vert ? region(nv, edge_v, win) : region(edge_v, nv, win);
        end else begin
          seg.x1 <= vert ? nv : edge_v;
          seg.y1 <= vert ? edge_v : nv;
          seg.c1 <= vert ? region(nv, edge_v, win) : region(edge_v, nv, win);
        end
      end
      default: ;
    endcase
  end

  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    pass <= PassW'(MaxPasses)) else $error("pass count overrun");
  a_rej_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_acc |-> out_data == '0) else $error("rejected data nonzero");
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");

endmodule

>>> sv/line_segment_rect_clipper.sv
// Cohen-Sutherland clipper: one segment in, clipped endpoints and accept flag
// out. An item is decided in the check state or takes clip passes (eight at
// most), each pass running the serial divider unless the divisor is zero.
// A two-entry queue sits before the clip engine.
// Depends on lsrc_pkg, lsrc_front, lsrc_back, lsrc_div.
module line_segment_rect_clipper
  import lsrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // start_x, start_y, end_x, end_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // clipped_start_x/y, clipped_end_x/y
  output logic        m_axis_tuser,  // accepted
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  window_t win;
  logic    q_valid, q_ready;
  seg_t    q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '{left: 16'sh8000, bottom: 16'sh8000, right: 16'sh7fff, top: 16'sh7fff};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LEFT:   win.left   <= cfg_data;
        REG_BOTTOM: win.bottom <= cfg_data;
        REG_RIGHT:  win.right  <= cfg_data;
        REG_TOP:    win.top    <= cfg_data;
        default: ;
      endcase
    end
  end

  lsrc_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .sx(s_axis_tdata[15:0]), .sy(s_axis_tdata[31:16]),
    .ex(s_axis_tdata[47:32]), .ey(s_axis_tdata[63:48]),
    .win, .q_valid, .q_ready, .q_data
  );

  lsrc_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data, .win,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_acc(m_axis_tuser)
  );

endmodule
